FILE: rtl/core/crs_pkg.sv
// Package for the Chinese remainder solver core.
// Holds the item types, the status codes and the default sizes; no dependencies.
package crs_pkg;

  // Default sizes for the top-level parameters.
  localparam int MAX_TERMS_DEF = 4;
  localparam int MOD_BITS_DEF  = 16;

  // Fixed field widths of the channels.
  localparam int IN_BITS   = 16;
  localparam int WIDE_BITS = 64;
  localparam int HALF_BITS = WIDE_BITS / 2;

  // Status codes of a result item.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_COPR  = 2'd1;
  localparam logic [1:0] ST_ZERO_MOD  = 2'd2;
  localparam logic [1:0] ST_TOO_MANY  = 2'd3;

  // One congruence.
  typedef struct packed {
    logic [IN_BITS-1:0] residue;
    logic [IN_BITS-1:0] modulus;
    logic               last;
  } in_item_t;

  // One solution.
  typedef struct packed {
    logic [WIDE_BITS-1:0] solution;
    logic [WIDE_BITS-1:0] product;
    logic [1:0]           status;
  } out_item_t;

endpackage

FILE: rtl/core/crs_front.sv
// Front part of the solver: accepts congruence items, trims them to MOD_BITS
// and holds them in a two-entry queue for the back part. Uses crs_pkg.
module crs_front #(
  parameter int MOD_BITS = crs_pkg::MOD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  crs_pkg::in_item_t item,
  output logic              q_valid,
  input  logic              q_pop,
  output crs_pkg::in_item_t q_item
);

  localparam logic [crs_pkg::IN_BITS-1:0] FIELD_MASK =
    crs_pkg::IN_BITS'((17'd1 << MOD_BITS) - 17'd1);

  crs_pkg::in_item_t slots [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        fill;
  logic              push;
  crs_pkg::in_item_t trimmed;

  // Only the low MOD_BITS bits of each field take part in the math.
  always_comb begin
    trimmed         = item;
    trimmed.residue = item.residue & FIELD_MASK;
    trimmed.modulus = item.modulus & FIELD_MASK;
  end

  assign item_ready = (fill != 2'd2);
  assign push       = item_valid && item_ready;
  assign q_valid    = (fill != 2'd0);
  assign q_item     = slots[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= trimmed;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !q_pop) begin
        fill <= fill + 2'd1;
      end else if (!push && q_pop) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

FILE: rtl/core/crs_div.sv
// Restoring divider for the solver: a 64-bit dividend by a MOD_BITS divisor,
// one quotient bit per cycle. Uses crs_pkg.
module crs_div #(
  parameter int MOD_BITS = crs_pkg::MOD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [crs_pkg::WIDE_BITS-1:0] dividend,
  input  logic [MOD_BITS-1:0]           divisor,
  output logic                          done,
  output logic [crs_pkg::WIDE_BITS-1:0] quo,
  output logic [MOD_BITS-1:0]           rem
);

  localparam int CW = $clog2(crs_pkg::WIDE_BITS);

  logic [MOD_BITS-1:0] dvs;
  logic [CW-1:0]       cnt;
  logic                busy;
  logic [MOD_BITS:0]   shifted;
  logic                fits;

  // One shift-and-subtract step.
  assign shifted = {rem, quo[crs_pkg::WIDE_BITS-1]};
  assign fits    = (shifted >= {1'b0, dvs});

  // Datapath.
  always_ff @(posedge clk) begin
    if (go) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[crs_pkg::WIDE_BITS-2:0], fits};
      rem <= fits ? MOD_BITS'(shifted - {1'b0, dvs}) : shifted[MOD_BITS-1:0];
    end
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(crs_pkg::WIDE_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/core/crs_mul.sv
// Multiplier for the solver: a 64-bit value times a MOD_BITS value, built from
// two half-width partial products and a combine step. Uses crs_pkg.
module crs_mul #(
  parameter int MOD_BITS = crs_pkg::MOD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [crs_pkg::WIDE_BITS-1:0] x,
  input  logic [MOD_BITS-1:0]           y,
  output logic                          done,
  output logic [crs_pkg::WIDE_BITS-1:0] prod
);

  localparam int HB = crs_pkg::HALF_BITS;
  localparam int PW = HB + MOD_BITS;

  logic [crs_pkg::WIDE_BITS-1:0] xr;
  logic [MOD_BITS-1:0]           yr;
  logic [PW-1:0]                 lo;
  logic [PW-1:0]                 hi;
  logic [2:0]                    phase;

  // Partial products, then the combine step.
  always_ff @(posedge clk) begin
    if (go) begin
      xr <= x;
      yr <= y;
    end
    if (phase[0]) begin
      lo <= xr[HB-1:0] * yr;
    end
    if (phase[1]) begin
      hi <= xr[crs_pkg::WIDE_BITS-1:HB] * yr;
    end
    if (phase[2]) begin
      prod <= crs_pkg::WIDE_BITS'(lo) + {hi[HB-1:0], {HB{1'b0}}};
    end
  end

  // Phase shift register and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      done  <= 1'b0;
    end else begin
      phase <= {phase[1:0], go};
      done  <= phase[2];
    end
  end

endmodule

FILE: rtl/core/crs_back.sv
// Back part of the solver: stores terms, checks them and runs the solve on a
// shared divider and multiplier. Uses crs_pkg, crs_div and crs_mul.
module crs_back #(
  parameter int MAX_TERMS = crs_pkg::MAX_TERMS_DEF,
  parameter int MOD_BITS  = crs_pkg::MOD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_pop,
  input  crs_pkg::in_item_t  q_item,
  output logic               result_valid,
  input  logic               result_ready,
  output crs_pkg::out_item_t result
);

  localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam int SW    = MOD_BITS + 2;
  localparam int QW    = 2 * MOD_BITS + 3;
  localparam int WB    = crs_pkg::WIDE_BITS;

  typedef enum logic [24:0] {
    S_IDLE = 25'h0000001, S_ZRD  = 25'h0000002, S_ZCK  = 25'h0000004,
    S_GA   = 25'h0000008, S_GB   = 25'h0000010, S_GC   = 25'h0000020,
    S_GDIV = 25'h0000040, S_GW   = 25'h0000080, S_PRD  = 25'h0000100,
    S_PMUL = 25'h0000200, S_PW   = 25'h0000400, S_TRD  = 25'h0000800,
    S_TLD  = 25'h0001000, S_TW1  = 25'h0002000, S_TW2  = 25'h0004000,
    S_TW3  = 25'h0008000, S_EDIV = 25'h0010000, S_EW   = 25'h0020000,
    S_EQ   = 25'h0040000, S_ES   = 25'h0080000, S_TM1  = 25'h0100000,
    S_TM1W = 25'h0200000, S_TD4W = 25'h0400000, S_TM2W = 25'h0800000,
    S_OUT  = 25'h1000000
  } state_t;

  // Term store.
  logic [MOD_BITS-1:0] res_mem [MAX_TERMS];
  logic [MOD_BITS-1:0] mod_mem [MAX_TERMS];
  logic [MOD_BITS-1:0] rd_res;
  logic [MOD_BITS-1:0] rd_mod;
  logic [IDX_W-1:0]    rd_idx;

  state_t              state;
  logic [CNT_W-1:0]    count;
  logic                overflow_seen;
  logic [IDX_W-1:0]    i;
  logic [IDX_W-1:0]    j;
  logic [1:0]          status;
  logic                store_ok;

  // Solve registers.
  logic [WB-1:0]       prod;
  logic [WB-1:0]       sol;
  logic [WB-1:0]       part;
  logic [MOD_BITS-1:0] ga;
  logic [MOD_BITS-1:0] gb;
  logic [MOD_BITS-1:0] tm;
  logic [MOD_BITS-1:0] tb;
  logic [MOD_BITS-1:0] r0;
  logic [MOD_BITS-1:0] r1;
  logic [MOD_BITS-1:0] q;
  logic [MOD_BITS-1:0] inv;
  logic signed [SW-1:0] s0;
  logic signed [SW-1:0] s1;
  logic signed [QW-1:0] qs;
  logic signed [QW-1:0] sdiff;
  logic signed [SW-1:0] s_pos;
  logic [WB-1:0]       gap;

  // Shared unit ports.
  logic                div_go;
  logic [WB-1:0]       div_a;
  logic [MOD_BITS-1:0] div_d;
  logic                div_done;
  logic [WB-1:0]       div_quo;
  logic [MOD_BITS-1:0] div_rem;
  logic                mul_go;
  logic [WB-1:0]       mul_x;
  logic [MOD_BITS-1:0] mul_y;
  logic                mul_done;
  logic [WB-1:0]       mul_res;

  crs_div #(.MOD_BITS(MOD_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_a),
    .divisor  (div_d),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  crs_mul #(.MOD_BITS(MOD_BITS)) u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (mul_go),
    .x    (mul_x),
    .y    (mul_y),
    .done (mul_done),
    .prod (mul_res)
  );

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign store_ok  = (count < CNT_W'(MAX_TERMS));
  assign rd_idx    = (state == S_GB) ? j : i;

  // Euclid helpers: the next coefficient and the final positive inverse.
  assign sdiff = QW'(s0) - qs;
  assign s_pos = s0[SW-1] ? (s0 + $signed({2'b00, tm})) : s0;
  assign gap   = prod - sol;

  // Store writes and registered reads.
  always_ff @(posedge clk) begin
    if (q_pop && store_ok) begin
      res_mem[count[IDX_W-1:0]] <= q_item.residue[MOD_BITS-1:0];
      mod_mem[count[IDX_W-1:0]] <= q_item.modulus[MOD_BITS-1:0];
    end
    rd_res <= res_mem[rd_idx];
    rd_mod <= mod_mem[rd_idx];
  end

  // Sequencer datapath registers.
  always_ff @(posedge clk) begin
    div_go <= 1'b0;
    mul_go <= 1'b0;
    case (state)
      S_GB: begin
        ga <= rd_mod;
      end
      S_GC: begin
        gb <= rd_mod;
      end
      S_GDIV: begin
        if (gb != '0) begin
          div_go <= 1'b1;
          div_a  <= WB'(ga);
          div_d  <= gb;
        end
      end
      S_GW: begin
        if (div_done) begin
          ga <= gb;
          gb <= div_rem;
        end
      end
      S_PMUL: begin
        mul_go <= 1'b1;
        mul_x  <= prod;
        mul_y  <= rd_mod;
      end
      S_PW: begin
        if (mul_done) begin
          prod <= mul_res;
          sol  <= '0;
        end
      end
      S_TLD: begin
        tm     <= rd_mod;
        tb     <= rd_res;
        div_go <= 1'b1;
        div_a  <= prod;
        div_d  <= rd_mod;
      end
      S_TW1: begin
        if (div_done) begin
          part   <= div_quo;
          div_go <= 1'b1;
          div_a  <= WB'(tb);
          div_d  <= tm;
        end
      end
      S_TW2: begin
        if (div_done) begin
          tb     <= div_rem;
          div_go <= 1'b1;
          div_a  <= part;
          div_d  <= tm;
        end
      end
      S_TW3: begin
        if (div_done) begin
          r0 <= div_rem;
          r1 <= tm;
          s0 <= SW'(1);
          s1 <= '0;
        end
      end
      S_EDIV: begin
        if (r1 == '0) begin
          inv <= s_pos[MOD_BITS-1:0];
        end else begin
          div_go <= 1'b1;
          div_a  <= WB'(r0);
          div_d  <= r1;
        end
      end
      S_EW: begin
        if (div_done) begin
          q  <= div_quo[MOD_BITS-1:0];
          r0 <= r1;
          r1 <= div_rem;
        end
      end
      S_EQ: begin
        qs <= $signed({1'b0, q}) * s1;
      end
      S_ES: begin
        s0 <= s1;
        s1 <= sdiff[SW-1:0];
      end
      S_TM1: begin
        mul_go <= 1'b1;
        mul_x  <= WB'(tb);
        mul_y  <= inv;
      end
      S_TM1W: begin
        if (mul_done) begin
          div_go <= 1'b1;
          div_a  <= mul_res;
          div_d  <= tm;
        end
      end
      S_TD4W: begin
        if (div_done) begin
          mul_go <= 1'b1;
          mul_x  <= part;
          mul_y  <= div_rem;
        end
      end
      default: begin
      end
    endcase
    // Modular accumulate once the product term is ready.
    if (state == S_TM2W && mul_done) begin
      if (mul_res >= gap) begin
        sol <= mul_res - gap;
      end else begin
        sol <= sol + mul_res;
      end
    end
    if (state == S_ZRD && i == '0) begin
      prod <= WB'(1);
    end
  end

  // Control flow, term count and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      overflow_seen <= 1'b0;
      i             <= '0;
      j             <= '0;
      status        <= crs_pkg::ST_OK;
      result_valid  <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            if (store_ok) begin
              count <= count + CNT_W'(1);
            end else begin
              overflow_seen <= 1'b1;
            end
            if (q_item.last) begin
              i <= '0;
              if (overflow_seen || !store_ok) begin
                status <= crs_pkg::ST_TOO_MANY;
                state  <= S_TM2W;
              end else begin
                status <= crs_pkg::ST_OK;
                state  <= S_ZRD;
              end
            end
          end
        end
        S_ZRD: begin
          state <= S_ZCK;
        end
        S_ZCK: begin
          if (rd_mod == '0) begin
            status <= crs_pkg::ST_ZERO_MOD;
            state  <= S_TM2W;
          end else if (CNT_W'(i) + CNT_W'(1) == count) begin
            i <= '0;
            j <= IDX_W'(1);
            state <= (count == CNT_W'(1)) ? S_PRD : S_GA;
          end else begin
            i     <= i + IDX_W'(1);
            state <= S_ZRD;
          end
        end
        S_GA: begin
          state <= S_GB;
        end
        S_GB: begin
          state <= S_GC;
        end
        S_GC: begin
          state <= S_GDIV;
        end
        S_GDIV: begin
          if (gb != '0) begin
            state <= S_GW;
          end else if (ga != MOD_BITS'(1)) begin
            status <= crs_pkg::ST_NOT_COPR;
            state  <= S_TM2W;
          end else if (CNT_W'(j) + CNT_W'(1) == count) begin
            if (CNT_W'(i) + CNT_W'(2) == count) begin
              i     <= '0;
              state <= S_PRD;
            end else begin
              i     <= i + IDX_W'(1);
              j     <= i + IDX_W'(2);
              state <= S_GA;
            end
          end else begin
            j     <= j + IDX_W'(1);
            state <= S_GA;
          end
        end
        S_GW: begin
          if (div_done) begin
            state <= S_GDIV;
          end
        end
        S_PRD: begin
          state <= S_PMUL;
        end
        S_PMUL: begin
          state <= S_PW;
        end
        S_PW: begin
          if (mul_done) begin
            if (CNT_W'(i) + CNT_W'(1) == count) begin
              i     <= '0;
              state <= S_TRD;
            end else begin
              i     <= i + IDX_W'(1);
              state <= S_PRD;
            end
          end
        end
        S_TRD: begin
          state <= S_TLD;
        end
        S_TLD: begin
          state <= S_TW1;
        end
        S_TW1: begin
          if (div_done) begin
            state <= S_TW2;
          end
        end
        S_TW2: begin
          if (div_done) begin
            state <= S_TW3;
          end
        end
        S_TW3: begin
          if (div_done) begin
            state <= S_EDIV;
          end
        end
        S_EDIV: begin
          state <= (r1 == '0) ? S_TM1 : S_EW;
        end
        S_EW: begin
          if (div_done) begin
            state <= S_EQ;
          end
        end
        S_EQ: begin
          state <= S_ES;
        end
        S_ES: begin
          state <= S_EDIV;
        end
        S_TM1: begin
          state <= S_TM1W;
        end
        S_TM1W: begin
          if (mul_done) begin
            state <= S_TD4W;
          end
        end
        S_TD4W: begin
          if (div_done) begin
            state <= S_TM2W;
          end
        end
        S_TM2W: begin
          // Error results arrive here directly and are handed off once the
          // result register is free; a finished term loops or goes to output.
          if (status != crs_pkg::ST_OK) begin
            if (!result_valid || result_ready) begin
              result_valid    <= 1'b1;
              result.solution <= '0;
              result.product  <= '0;
              result.status   <= status;
              count           <= '0;
              overflow_seen   <= 1'b0;
              state           <= S_IDLE;
            end
          end else if (mul_done) begin
            if (CNT_W'(i) + CNT_W'(1) == count) begin
              state <= S_OUT;
            end else begin
              i     <= i + IDX_W'(1);
              state <= S_TRD;
            end
          end
        end
        S_OUT: begin
          // Wait until the previous result has been taken.
          if (!result_valid || result_ready) begin
            result_valid    <= 1'b1;
            result.solution <= sol;
            result.product  <= prod;
            result.status   <= crs_pkg::ST_OK;
            count           <= '0;
            overflow_seen   <= 1'b0;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/chinese_remainder_solver_core.sv
// Chinese remainder solver core. An item without last is stored through the
// two-entry input queue, one item per cycle while the queue has room and the
// back part is idle. A closing item starts the solve, which runs its divisions
// on the shared 64-step divider (issue, load, 64 steps, hand-back).
// Reset clears the queue, the term count, the error flag and the result valid.
module chinese_remainder_solver_core #(
  parameter int MAX_TERMS = crs_pkg::MAX_TERMS_DEF,
  parameter int MOD_BITS  = crs_pkg::MOD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  crs_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_ready,
  output crs_pkg::out_item_t result
);

  logic              q_valid;
  logic              q_pop;
  crs_pkg::in_item_t q_item;

  crs_front #(.MOD_BITS(MOD_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item)
  );

  crs_back #(.MAX_TERMS(MAX_TERMS), .MOD_BITS(MOD_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_item       (q_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
